FILE: rtl/fixed_point_q24_8_alu_defines.svh
// Assertion helpers for the fixed-point ALU.
`ifndef FIXED_POINT_Q24_8_ALU_DEFINES_SVH
`define FIXED_POINT_Q24_8_ALU_DEFINES_SVH

// same-cycle implication, clocked on clk, off during reset
`define FPA_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fixed-point ALU check failed");

// next-cycle implication
`define FPA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fixed-point ALU check failed");

`endif

FILE: rtl/fpa_pkg.sv
package fpa_pkg;

    localparam int WORD_WIDTH = 32;
    localparam int FRAC_BITS  = 8;
    localparam int QUO_WIDTH  = WORD_WIDTH + FRAC_BITS;
    localparam int PROD_WIDTH = 2 * WORD_WIDTH;

    localparam logic [WORD_WIDTH-1:0] MAX_WORD = {1'b0, {(WORD_WIDTH-1){1'b1}}};
    localparam logic [WORD_WIDTH-1:0] MIN_WORD = {1'b1, {(WORD_WIDTH-1){1'b0}}};

    typedef enum logic [3:0] {
        OP_ADD      = 4'd0,
        OP_SUB      = 4'd1,
        OP_MUL      = 4'd2,
        OP_DIV      = 4'd3,
        OP_LT       = 4'd4,
        OP_LE       = 4'd5,
        OP_GT       = 4'd6,
        OP_GE       = 4'd7,
        OP_EQ       = 4'd8,
        OP_NE       = 4'd9,
        OP_MIN      = 4'd10,
        OP_MAX      = 4'd11,
        OP_INC      = 4'd12,
        OP_DEC      = 4'd13,
        OP_FROM_INT = 4'd14,
        OP_TO_INT   = 4'd15
    } op_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_OVF  = 2'd1,
        ST_DIVZ = 2'd2
    } status_t;

    // restoring divider state, one quotient bit per stage
    typedef struct packed {
        logic [QUO_WIDTH-1:0]  num;
        logic [WORD_WIDTH-1:0] den;
        logic [WORD_WIDTH-1:0] rem;
        logic [QUO_WIDTH-1:0]  quo;
    } div_t;

    // per-transaction sideband carried down the pipe
    typedef struct packed {
        logic                  is_div;
        logic                  is_mul;
        logic                  neg;
        logic [WORD_WIDTH-1:0] result;
        logic                  cmp;
        status_t               status;
    } side_t;

endpackage

FILE: rtl/fpa_front.sv
module fpa_front (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             en,
    input  logic                             in_valid,
    input  logic [3:0]                       cmd,
    input  logic signed [fpa_pkg::WORD_WIDTH-1:0] operand_a,
    input  logic signed [fpa_pkg::WORD_WIDTH-1:0] operand_b,
    output logic                             valid_reg,
    output fpa_pkg::div_t                    div_reg,
    output fpa_pkg::side_t                   side_reg
);

    fpa_pkg::div_t  div_next;
    fpa_pkg::side_t side_next;

    always_comb
    begin
        fpa_pkg::op_t                     op;
        logic [fpa_pkg::WORD_WIDTH:0]     ax;
        logic [fpa_pkg::WORD_WIDTH:0]     addx;
        logic [fpa_pkg::WORD_WIDTH:0]     sum;
        logic [fpa_pkg::WORD_WIDTH-1:0]   ma;
        logic [fpa_pkg::WORD_WIDTH-1:0]   mb;
        logic                             lt;
        logic                             gt;
        logic                             eq;
        logic                             b_zero;
        logic [fpa_pkg::FRAC_BITS:0]      top_bits;

        op     = fpa_pkg::op_t'(cmd);
        ax     = {operand_a[fpa_pkg::WORD_WIDTH-1], operand_a};
        if (op == fpa_pkg::OP_INC || op == fpa_pkg::OP_DEC)
        begin
            addx = (fpa_pkg::WORD_WIDTH+1)'(1);
        end
        else
        begin
            addx = {operand_b[fpa_pkg::WORD_WIDTH-1], operand_b};
        end
        if (op == fpa_pkg::OP_SUB || op == fpa_pkg::OP_DEC)
        begin
            sum = ax - addx;
        end
        else
        begin
            sum = ax + addx;
        end
        ma = operand_a[fpa_pkg::WORD_WIDTH-1] ? -operand_a : operand_a;
        mb = operand_b[fpa_pkg::WORD_WIDTH-1] ? -operand_b : operand_b;
        lt = operand_a < operand_b;
        gt = operand_b < operand_a;
        eq = operand_a == operand_b;
        b_zero   = operand_b == '0;
        top_bits = operand_a[fpa_pkg::WORD_WIDTH-1 -: fpa_pkg::FRAC_BITS+1];

        div_next.num = {ma, {fpa_pkg::FRAC_BITS{1'b0}}};
        div_next.den = mb;
        div_next.rem = '0;
        div_next.quo = '0;

        side_next.is_div = (op == fpa_pkg::OP_DIV) && !b_zero;
        side_next.is_mul = op == fpa_pkg::OP_MUL;
        side_next.neg    = operand_a[fpa_pkg::WORD_WIDTH-1] ^ operand_b[fpa_pkg::WORD_WIDTH-1];
        side_next.result = '0;
        side_next.cmp    = 1'b0;
        side_next.status = fpa_pkg::ST_OK;

        case (op)
            fpa_pkg::OP_ADD, fpa_pkg::OP_SUB, fpa_pkg::OP_INC, fpa_pkg::OP_DEC:
            begin
                if (sum[fpa_pkg::WORD_WIDTH] != sum[fpa_pkg::WORD_WIDTH-1])
                begin
                    side_next.status = fpa_pkg::ST_OVF;
                    side_next.result = sum[fpa_pkg::WORD_WIDTH] ?
                                       fpa_pkg::MIN_WORD : fpa_pkg::MAX_WORD;
                end
                else
                begin
                    side_next.result = sum[fpa_pkg::WORD_WIDTH-1:0];
                end
            end
            fpa_pkg::OP_MUL:
            begin
                side_next.result = '0;
            end
            fpa_pkg::OP_DIV:
            begin
                if (b_zero)
                begin
                    side_next.status = fpa_pkg::ST_DIVZ;
                    if (operand_a == '0)
                    begin
                        side_next.result = '0;
                    end
                    else
                    begin
                        side_next.result = operand_a[fpa_pkg::WORD_WIDTH-1] ?
                                           fpa_pkg::MIN_WORD : fpa_pkg::MAX_WORD;
                    end
                end
            end
            fpa_pkg::OP_LT: side_next.cmp = lt;
            fpa_pkg::OP_LE: side_next.cmp = !gt;
            fpa_pkg::OP_GT: side_next.cmp = gt;
            fpa_pkg::OP_GE: side_next.cmp = !lt;
            fpa_pkg::OP_EQ: side_next.cmp = eq;
            fpa_pkg::OP_NE: side_next.cmp = !eq;
            fpa_pkg::OP_MIN: side_next.result = lt ? operand_a : operand_b;
            fpa_pkg::OP_MAX: side_next.result = gt ? operand_a : operand_b;
            fpa_pkg::OP_FROM_INT:
            begin
                if (top_bits != {(fpa_pkg::FRAC_BITS+1){operand_a[fpa_pkg::WORD_WIDTH-1]}})
                begin
                    side_next.status = fpa_pkg::ST_OVF;
                    side_next.result = operand_a[fpa_pkg::WORD_WIDTH-1] ?
                                       fpa_pkg::MIN_WORD : fpa_pkg::MAX_WORD;
                end
                else
                begin
                    side_next.result = {operand_a[fpa_pkg::WORD_WIDTH-1-fpa_pkg::FRAC_BITS:0],
                                        {fpa_pkg::FRAC_BITS{1'b0}}};
                end
            end
            default:
            begin
                side_next.result = fpa_pkg::WORD_WIDTH'(operand_a >>> fpa_pkg::FRAC_BITS);
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            div_reg  <= div_next;
            side_reg <= side_next;
        end
    end

endmodule

FILE: rtl/fpa_div_stage.sv
module fpa_div_stage (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  logic           valid_in,
    input  fpa_pkg::div_t  div_in,
    input  fpa_pkg::side_t side_in,
    output logic           valid_reg,
    output fpa_pkg::div_t  div_reg,
    output fpa_pkg::side_t side_reg
);

    fpa_pkg::div_t div_next;

    always_comb
    begin
        logic [fpa_pkg::WORD_WIDTH:0] trial;
        logic                         ge;

        trial = {div_in.rem, div_in.num[fpa_pkg::QUO_WIDTH-1]};
        ge    = trial >= {1'b0, div_in.den};
        div_next.den = div_in.den;
        div_next.num = {div_in.num[fpa_pkg::QUO_WIDTH-2:0], 1'b0};
        div_next.quo = {div_in.quo[fpa_pkg::QUO_WIDTH-2:0], ge};
        if (ge)
        begin
            div_next.rem = fpa_pkg::WORD_WIDTH'(trial - {1'b0, div_in.den});
        end
        else
        begin
            div_next.rem = trial[fpa_pkg::WORD_WIDTH-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            div_reg  <= div_next;
            side_reg <= side_in;
        end
    end

endmodule

FILE: rtl/fixed_point_q24_8_alu.sv
// channel | handshake              | payload
// input   | in_valid / in_stall    | cmd, operand_a, operand_b
// output  | out_valid / out_stall  | result_value, compare_true, status
//
// Fully pipelined: one transaction per cycle while the output is not stalled.
// The divider makes one quotient bit per stage; all opcodes pass through it.
// Multiply adds one 32x32 product stage; its round/saturate logic is combinational.
// Reset clears only the valid bits; no state survives between transactions.
// A stalled full output register freezes the whole pipe; in_stall follows it.
`include "fixed_point_q24_8_alu_defines.svh"

module fixed_point_q24_8_alu (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic [3:0]                            cmd,
    input  logic signed [fpa_pkg::WORD_WIDTH-1:0] operand_a,
    input  logic signed [fpa_pkg::WORD_WIDTH-1:0] operand_b,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic signed [fpa_pkg::WORD_WIDTH-1:0] result_value,
    output logic                                  compare_true,
    output logic [1:0]                            status
);

    localparam int NST = fpa_pkg::QUO_WIDTH;

    logic           en;
    logic           valid_pipe [NST+1];
    fpa_pkg::div_t  div_pipe   [NST+1];
    fpa_pkg::side_t side_pipe  [NST+1];
    fpa_pkg::side_t mul_side;

    logic [fpa_pkg::PROD_WIDTH-1:0] prod_reg;

    logic                           out_valid_reg;
    logic [fpa_pkg::WORD_WIDTH-1:0] result_reg;
    logic [fpa_pkg::WORD_WIDTH-1:0] result_next;
    logic                           cmp_reg;
    fpa_pkg::status_t               status_reg;
    fpa_pkg::status_t               status_next;

    assign en       = !out_valid_reg || !out_stall;
    assign in_stall = !en;

    fpa_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (in_valid),
        .cmd       (cmd),
        .operand_a (operand_a),
        .operand_b (operand_b),
        .valid_reg (valid_pipe[0]),
        .div_reg   (div_pipe[0]),
        .side_reg  (side_pipe[0])
    );

    // multiply: magnitudes from the front stage
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= fpa_pkg::PROD_WIDTH'(div_pipe[0].num[NST-1:fpa_pkg::FRAC_BITS])
                      * fpa_pkg::PROD_WIDTH'(div_pipe[0].den);
        end
    end

    always_comb
    begin
        logic [fpa_pkg::PROD_WIDTH-1:0] rounded;
        logic [fpa_pkg::PROD_WIDTH-1:0] shifted;
        logic [fpa_pkg::PROD_WIDTH-1:0] limit;

        rounded  = prod_reg + (fpa_pkg::PROD_WIDTH'(1) << (fpa_pkg::FRAC_BITS-1));
        shifted  = rounded >> fpa_pkg::FRAC_BITS;
        limit    = side_pipe[1].neg ? fpa_pkg::PROD_WIDTH'(fpa_pkg::MIN_WORD)
                                    : fpa_pkg::PROD_WIDTH'(fpa_pkg::MAX_WORD);
        mul_side = side_pipe[1];
        if (side_pipe[1].is_mul)
        begin
            if (shifted > limit)
            begin
                mul_side.status = fpa_pkg::ST_OVF;
                mul_side.result = side_pipe[1].neg ? fpa_pkg::MIN_WORD : fpa_pkg::MAX_WORD;
            end
            else if (side_pipe[1].neg)
            begin
                mul_side.result = -shifted[fpa_pkg::WORD_WIDTH-1:0];
            end
            else
            begin
                mul_side.result = shifted[fpa_pkg::WORD_WIDTH-1:0];
            end
        end
    end

    for (genvar k = 0; k < NST; k++)
    begin : g_div
        fpa_pkg::side_t side_in;
        if (k == 1)
        begin : g_mul_merge
            assign side_in = mul_side;
        end
        else
        begin : g_plain
            assign side_in = side_pipe[k];
        end

        fpa_div_stage u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .valid_in  (valid_pipe[k]),
            .div_in    (div_pipe[k]),
            .side_in   (side_in),
            .valid_reg (valid_pipe[k+1]),
            .div_reg   (div_pipe[k+1]),
            .side_reg  (side_pipe[k+1])
        );
    end

    // divide rounding and saturation
    always_comb
    begin
        fpa_pkg::div_t          d;
        fpa_pkg::side_t         s;
        logic                   round_up;
        logic [NST:0]           q;
        logic [NST:0]           limit;

        d        = div_pipe[NST];
        s        = side_pipe[NST];
        round_up = {d.rem, 1'b0} >= {1'b0, d.den};
        q        = {1'b0, d.quo} + (NST+1)'(round_up);
        limit    = s.neg ? (NST+1)'(fpa_pkg::MIN_WORD) : (NST+1)'(fpa_pkg::MAX_WORD);
        result_next = s.result;
        status_next = s.status;
        if (s.is_div)
        begin
            if (q > limit)
            begin
                status_next = fpa_pkg::ST_OVF;
                result_next = s.neg ? fpa_pkg::MIN_WORD : fpa_pkg::MAX_WORD;
            end
            else if (s.neg)
            begin
                result_next = -q[fpa_pkg::WORD_WIDTH-1:0];
            end
            else
            begin
                result_next = q[fpa_pkg::WORD_WIDTH-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= valid_pipe[NST];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            result_reg <= result_next;
            cmp_reg    <= side_pipe[NST].cmp;
            status_reg <= status_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign result_value = result_reg;
    assign compare_true = cmp_reg;
    assign status       = status_reg;

    `FPA_ASSERT_NOW(a_stall_cause, in_stall, out_valid && out_stall)
    `FPA_ASSERT_NOW(a_cmp_clean, out_valid && compare_true,
                    result_value == '0 && status == fpa_pkg::ST_OK)
    `FPA_ASSERT_NOW(a_ovf_sat, out_valid && status == fpa_pkg::ST_OVF,
                    result_value == fpa_pkg::MAX_WORD || result_value == fpa_pkg::MIN_WORD)
    `FPA_ASSERT_NEXT(a_freeze, out_valid && out_stall, out_valid && $stable(valid_pipe[NST]))

endmodule
